@@ src/hkrcq_pkg.sv @@
// shared types and constants for the keyboard report change queue
package hkrcq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int KEY_SLOTS_DEF   = 6;
   localparam int RAW_SLOTS       = 6;

   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BAD_LEN = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_NO_DATA = 3'd3;
   localparam logic [2:0] ST_DATA    = 3'd4;

   localparam logic [6:0] REPORT_LEN = 7'd8;
   localparam logic [7:0] CODE_NONE  = 8'h00;
   localparam logic [7:0] CODE_ERROR = 8'h01;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] report_len;
      logic [7:0] modifier_in;
      logic [7:0] key_in_0;
      logic [7:0] key_in_1;
      logic [7:0] key_in_2;
      logic [7:0] key_in_3;
      logic [7:0] key_in_4;
      logic [7:0] key_in_5;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] modifier_out;
      logic [2:0] key_total;
      logic [7:0] key_out_0;
      logic [7:0] key_out_1;
      logic [7:0] key_out_2;
      logic [7:0] key_out_3;
      logic [7:0] key_out_4;
      logic [7:0] key_out_5;
   } rsp_item_type;

   // one queued entry: modifier, key count, packed key codes
   typedef struct packed {
      logic [RAW_SLOTS-1:0][7:0] key;
      logic [2:0]                key_total;
      logic [7:0]                modifier;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ src/hkrcq_ram.sv @@
// generic single write port ram with registered read
module hkrcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/hkrcq_pack.sv @@
// compacts the valid key codes of a report into leading slots
module hkrcq_pack #(
   parameter int KEY_SLOTS = hkrcq_pkg::KEY_SLOTS_DEF
) (
   input  hkrcq_pkg::req_item_type req_item,
   output hkrcq_pkg::entry_type    entry
);
   import hkrcq_pkg::*;

   logic [RAW_SLOTS-1:0][7:0] raw;
   logic [RAW_SLOTS-1:0][7:0] keys;
   logic [2:0]                count;

   assign raw = {req_item.key_in_5, req_item.key_in_4, req_item.key_in_3,
                 req_item.key_in_2, req_item.key_in_1, req_item.key_in_0};

   always_comb begin
      keys  = '0;
      count = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (raw[i] != CODE_NONE && raw[i] != CODE_ERROR) begin
            keys[count] = raw[i];
            count       = count + 3'd1;
         end
      end
   end

   assign entry.modifier  = req_item.modifier_in;
   assign entry.key_total = count;
   assign entry.key       = keys;

endmodule

@@ src/hid_keyboard_report_change_queue.sv @@
// keyboard report change queue: queue control, entry ram and response stage
// a result passes through stage one (status, ram read) and then the response register
// one item per cycle unless rsp_ready stalls; the registered ram read sets the depth
// a waiting result does not block the next item, a second one stalls req_ready
// reset clears pointers, fill level, last state and pipeline valids
// entry ram contents are not cleared and are only read once written
module hid_keyboard_report_change_queue #(
   parameter int QUEUE_DEPTH = hkrcq_pkg::QUEUE_DEPTH_DEF,
   parameter int KEY_SLOTS   = hkrcq_pkg::KEY_SLOTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  hkrcq_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hkrcq_pkg::rsp_item_type rsp_item
);
   import hkrcq_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   entry_type         prev_ff, prev_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_status_ff, s1_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   entry_type         entry_new;
   entry_type         entry_rd;
   logic              accept;
   logic              s1_advance;
   logic              wr_en;
   logic              rd_en;

   hkrcq_pack #(
      .KEY_SLOTS(KEY_SLOTS)
   ) u_pack (
      .req_item(req_item),
      .entry   (entry_new)
   );

   hkrcq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_ptr_ff),
      .wr_data(entry_new),
      .rd_en  (rd_en),
      .rd_addr(rd_ptr_ff),
      .rd_data(entry_rd)
   );

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   // queue control, decided as the item is accepted
   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      prev_in      = prev_ff;
      s1_status_in = s1_status_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      if (accept) begin
         s1_status_in = ST_OK;
         case (req_item.op)
            OP_REPORT: begin
               if (req_item.report_len != REPORT_LEN) begin
                  s1_status_in = ST_BAD_LEN;
               end else if (entry_new != prev_ff) begin
                  if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
                     s1_status_in = ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                 : wr_ptr_ff + PTR_W'(1);
                     fill_in   = fill_ff + FILL_W'(1);
                     prev_in   = entry_new;
                  end
               end
            end
            OP_POP: begin
               if (fill_ff == '0) begin
                  s1_status_in = ST_NO_DATA;
               end else begin
                  rd_en        = 1'b1;
                  rd_ptr_in    = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                 : rd_ptr_ff + PTR_W'(1);
                  fill_in      = fill_ff - FILL_W'(1);
                  s1_status_in = ST_DATA;
               end
            end
            OP_CLEAR: begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
               fill_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // ram data holds while stage one waits, as no read is issued then
   always_comb begin
      rsp_item_in        = '0;
      rsp_item_in.status = s1_status_ff;
      if (s1_status_ff == ST_DATA) begin
         rsp_item_in.modifier_out = entry_rd.modifier;
         rsp_item_in.key_total    = entry_rd.key_total;
         rsp_item_in.key_out_0    = entry_rd.key[0];
         rsp_item_in.key_out_1    = entry_rd.key[1];
         rsp_item_in.key_out_2    = entry_rd.key[2];
         rsp_item_in.key_out_3    = entry_rd.key[3];
         rsp_item_in.key_out_4    = entry_rd.key[4];
         rsp_item_in.key_out_5    = entry_rd.key[5];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         prev_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         prev_ff      <= prev_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      if (s1_advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ dv/report_queue_checker.sv @@
// response predictor and scoreboard for the keyboard report change queue
module report_queue_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  hkrcq_pkg::req_item_type req_item,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  hkrcq_pkg::rsp_item_type rsp_item,
   output int                      mismatch_count,
   output int                      responses_pending
);
   import hkrcq_pkg::*;

   entry_type    queued_entries[$];
   entry_type    last_stored_entry = '0;
   rsp_item_type expected_responses[$];
   int           mismatches = 0;
   int           pending = 0;

   assign mismatch_count    = mismatches;
   assign responses_pending = pending;

   // modifier kept, usable key codes moved down into the leading slots
   function automatic entry_type pack_report(req_item_type it);
      logic [RAW_SLOTS-1:0][7:0] raw;
      entry_type                 e;
      int                        n;
      raw = {it.key_in_5, it.key_in_4, it.key_in_3, it.key_in_2, it.key_in_1, it.key_in_0};
      e = '0;
      n = 0;
      for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
         if (raw[i] != CODE_NONE && raw[i] != CODE_ERROR) begin
            e.key[n] = raw[i];
            n++;
         end
      end
      e.key_total = 3'(n);
      e.modifier  = it.modifier_in;
      return e;
   endfunction

   function automatic rsp_item_type predict_response(req_item_type it);
      rsp_item_type r;
      entry_type    e;
      r = '0;
      r.status = ST_OK;
      case (it.op)
         OP_REPORT: begin
            if (it.report_len != REPORT_LEN) begin
               r.status = ST_BAD_LEN;
            end else begin
               e = pack_report(it);
               if (e != last_stored_entry) begin
                  if (queued_entries.size() >= QUEUE_DEPTH_DEF) begin
                     r.status = ST_FULL;
                  end else begin
                     queued_entries.push_back(e);
                     last_stored_entry = e;
                  end
               end
            end
         end
         OP_POP: begin
            if (queued_entries.size() == 0) begin
               r.status = ST_NO_DATA;
            end else begin
               e = queued_entries.pop_front();
               r.status       = ST_DATA;
               r.modifier_out = e.modifier;
               r.key_total    = e.key_total;
               r.key_out_0    = e.key[0];
               r.key_out_1    = e.key[1];
               r.key_out_2    = e.key[2];
               r.key_out_3    = e.key[3];
               r.key_out_4    = e.key[4];
               r.key_out_5    = e.key[5];
            end
         end
         OP_CLEAR: begin
            // last stored entry survives a clear
            queued_entries.delete();
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic compare_response(rsp_item_type exp, rsp_item_type got);
      string bad;
      bad = "";
      if (got.status !== exp.status) bad = {bad, " status"};
      if (got.modifier_out !== exp.modifier_out) bad = {bad, " modifier_out"};
      if (got.key_total !== exp.key_total) bad = {bad, " key_total"};
      if (got.key_out_0 !== exp.key_out_0) bad = {bad, " key_out_0"};
      if (got.key_out_1 !== exp.key_out_1) bad = {bad, " key_out_1"};
      if (got.key_out_2 !== exp.key_out_2) bad = {bad, " key_out_2"};
      if (got.key_out_3 !== exp.key_out_3) bad = {bad, " key_out_3"};
      if (got.key_out_4 !== exp.key_out_4) bad = {bad, " key_out_4"};
      if (got.key_out_5 !== exp.key_out_5) bad = {bad, " key_out_5"};
      if (bad != "") begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch in%s: expected %h, got %h", bad, exp, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response with nothing outstanding: got %h", rsp_item);
            end else begin
               compare_response(expected_responses.pop_front(), rsp_item);
            end
         end
         if (req_valid && req_ready)
            expected_responses.push_back(predict_response(req_item));
      end
      pending = expected_responses.size();
   end

endmodule

@@ dv/tb_top.sv @@
// testbench top: clock, reset, item stimulus, idling and final verdict
module tb_top;
   import hkrcq_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         ITEM_TOTAL  = 1800;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         REQ_W       = $bits(req_item_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   int           mismatch_count;
   int           responses_pending;
   int           idle_pct = 0;
   int           stall_pct = 0;
   int           cycle_count = 0;
   req_item_type last_report = '0;

   always #2 clock = ~clock;

   hid_keyboard_report_change_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   report_queue_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_item          (req_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item          (rsp_item),
      .mismatch_count    (mismatch_count),
      .responses_pending (responses_pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_item_type report_item(logic [6:0] len, logic [7:0] modifier,
                                                logic [7:0] k0, logic [7:0] k1, logic [7:0] k2,
                                                logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
      req_item_type it;
      it = '{OP_REPORT, len, modifier, k0, k1, k2, k3, k4, k5};
      return it;
   endfunction

   // payload bits other than op are don't-care for commands, so randomise them
   function automatic req_item_type command_item(logic [1:0] op);
      req_item_type it;
      it = req_item_type'(REQ_W'({$urandom, $urandom, $urandom}));
      it.op = op;
      return it;
   endfunction

   function automatic logic [7:0] random_key();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) return CODE_NONE;
      if (pick < 45) return CODE_ERROR;
      return 8'($urandom_range(255, 2));
   endfunction

   function automatic req_item_type random_report();
      req_item_type it;
      it = report_item(REPORT_LEN, 8'($urandom), random_key(), random_key(), random_key(),
                       random_key(), random_key(), random_key());
      if ($urandom_range(99) < 8) it.report_len = 7'($urandom_range(64));
      return it;
   endfunction

   // item held until accepted; ready is looked at mid-cycle to stay clear of the edge
   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int           phase_target;
      int           sent;
      int           burst;
      int           kind;
      req_item_type it;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_item(command_item(OP_POP));
      send_item(command_item(OP_UNUSED));
      send_item(report_item(REPORT_LEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_item(report_item(7'd0, 8'h12, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_item(report_item(7'd7, 8'h12, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_item(report_item(7'd9, 8'h12, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_item(report_item(7'd64, 8'h12, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_item(report_item(REPORT_LEN, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
      send_item(report_item(REPORT_LEN, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
      send_item(report_item(REPORT_LEN, 8'h02, 8'h00, 8'h01, 8'h04, 8'h00, 8'h01, 8'h05));
      // all error codes pack down to an empty entry, which still differs from the last one
      send_item(report_item(REPORT_LEN, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
      send_item(report_item(REPORT_LEN, 8'h55, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h02));
      repeat (5) send_item(command_item(OP_POP));
      send_item(report_item(REPORT_LEN, 8'haa, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h39));
      send_item(command_item(OP_CLEAR));
      send_item(command_item(OP_POP));
      send_item(report_item(REPORT_LEN, 8'haa, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h39));
      send_item(report_item(REPORT_LEN, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
      send_item(command_item(OP_POP));
      sent = 24;

      // random bursts; four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase
         phase_target = ITEM_TOTAL * (phase + 1) / 4;
         while (sent < phase_target) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
               // report runs long enough to fill the queue, with repeats mixed in
               burst = $urandom_range(24, 1);
               repeat (burst) begin
                  if ($urandom_range(99) < 15) begin
                     it = last_report;
                  end else begin
                     it = random_report();
                     last_report = it;
                  end
                  send_item(it);
                  sent++;
               end
            end else if (kind < 85) begin
               burst = $urandom_range(18, 1);
               repeat (burst) begin
                  send_item(command_item(OP_POP));
                  sent++;
               end
            end else if (kind < 91) begin
               send_item(command_item(OP_CLEAR));
               sent++;
            end else if (kind < 94) begin
               send_item(command_item(OP_UNUSED));
            end else begin
               burst = $urandom_range(5, 1);
               repeat (burst) begin
                  it = req_item_type'(REQ_W'({$urandom, $urandom, $urandom}));
                  it.report_len = 7'($urandom_range(64));
                  send_item(it);
                  if (it.op != OP_UNUSED) sent++;
               end
            end
         end
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (responses_pending != 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
src/hkrcq_pkg.sv
src/hkrcq_ram.sv
src/hkrcq_pack.sv
src/hid_keyboard_report_change_queue.sv
dv/report_queue_checker.sv
dv/tb_top.sv
